@@ rtl/ssspg_pkg.sv @@
// Shared types, status codes and constants for the step pulse generator.
`default_nettype none

package ssspg_pkg;

    localparam int unsigned AddrWidth  = 7;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned CountWidth = 15;
    localparam int unsigned IndexWidth = 2;

    localparam logic [3:0] ST_RXDATA = 4'd0;
    localparam logic [3:0] ST_STOP   = 4'd1;
    localparam logic [3:0] ST_ADDR   = 4'd2;
    localparam logic [3:0] ST_TXDATA = 4'd4;
    localparam logic [3:0] ST_TXSTOP = 4'd5;

    localparam logic [0:0] CFG_SLAVE_ADDRESS = 1'd0;
    localparam logic [0:0] CFG_READ_REPLY    = 1'd1;

    localparam logic [AddrWidth-1:0] SLAVE_ADDRESS_RESET = 7'd121;
    localparam logic [ByteWidth-1:0] READ_REPLY_RESET    = 8'd253;

    localparam logic [IndexWidth-1:0] INDEX_ONE = 2'd1;
    localparam logic [IndexWidth-1:0] INDEX_TWO = 2'd2;

    typedef struct packed {
        logic                 command;
        logic [3:0]           bus_status;
        logic [ByteWidth-1:0] rx_byte;
        logic                 arb_lost;
        logic                 master_ack;
    } item_t;

    typedef struct packed {
        logic                 ack_out;
        logic                 tx_load;
        logic [ByteWidth-1:0] tx_byte;
        logic                 bus_reset;
        logic                 command_loaded;
        logic                 pulse_level;
        logic                 dir_level;
        logic                 busy_res;
    } result_t;

    typedef struct packed {
        logic [AddrWidth-1:0] slave_address;
        logic [ByteWidth-1:0] read_reply;
    } cfg_t;

    typedef struct packed {
        logic [IndexWidth-1:0] tx_index;
        logic [IndexWidth-1:0] rx_index;
        logic [ByteWidth-1:0]  rx_high;
        logic [CountWidth-1:0] step_target;
        logic                  run_direction;
        logic [CountWidth-1:0] step_count;
        logic                  running;
        logic                  pulse_state;
        logic                  dir_state;
    } state_t;

endpackage

`default_nettype wire

@@ rtl/ssspg_cfg.sv @@
// Configuration registers: slave address and read reply byte.
`default_nettype none

module ssspg_cfg
    import ssspg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [ByteWidth-1:0] cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS: cfg_next.slave_address = cfg_data[AddrWidth-1:0];
                CFG_READ_REPLY:    cfg_next.read_reply    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address <= SLAVE_ADDRESS_RESET;
            cfg_reg.read_reply    <= READ_REPLY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/ssspg_core.sv @@
// Bus event decode, command assembly and step run state, one item per cycle when advance is high.
`default_nettype none

module ssspg_core
    import ssspg_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic advance,
    input  item_t     item,
    input  cfg_t      cfg,
    output result_t   result
);

    state_t  state_reg;
    state_t  state_next;
    result_t res;
    logic [ByteWidth-1:0] rx_low;
    logic [2*ByteWidth-1:0] word;

    always_comb begin
        state_next = state_reg;
        res        = '0;
        rx_low     = item.rx_byte;
        word       = {state_reg.rx_high, rx_low};

        if (item.command) begin
            if (state_reg.running) begin
                if (state_reg.step_count < state_reg.step_target) begin
                    state_next.dir_state   = state_reg.run_direction;
                    state_next.pulse_state = ~state_reg.pulse_state;
                    state_next.step_count  = state_reg.step_count + 1'b1;
                end else begin
                    state_next.step_count = '0;
                    state_next.running    = 1'b0;
                end
            end
        end else if (!item.arb_lost) begin
            unique case (item.bus_status)
                ST_ADDR: begin
                    state_next.tx_index = INDEX_ONE;
                    state_next.rx_index = INDEX_ONE;
                    if (item.rx_byte[ByteWidth-1:1] == cfg.slave_address) begin
                        res.ack_out = 1'b1;
                        if (item.rx_byte[0]) begin
                            res.tx_load         = 1'b1;
                            res.tx_byte         = cfg.read_reply;
                            state_next.tx_index = INDEX_TWO;
                        end
                    end
                end
                ST_RXDATA: begin
                    res.ack_out = 1'b1;
                    if (state_reg.rx_index < INDEX_TWO) begin
                        state_next.rx_high  = item.rx_byte;
                        state_next.rx_index = state_reg.rx_index + 1'b1;
                    end else begin
                        res.command_loaded       = 1'b1;
                        state_next.run_direction = word[2*ByteWidth-1];
                        state_next.step_target   = word[CountWidth-1:0];
                        state_next.running       = 1'b1;
                    end
                end
                ST_TXDATA: begin
                    if (item.master_ack && state_reg.tx_index <= INDEX_ONE) begin
                        res.tx_load         = 1'b1;
                        res.tx_byte         = cfg.read_reply;
                        state_next.tx_index = state_reg.tx_index + 1'b1;
                    end
                end
                ST_STOP, ST_TXSTOP: begin
                    res.ack_out = 1'b0;
                end
                default: begin
                    res.bus_reset = 1'b1;
                end
            endcase
        end

        res.pulse_level = state_next.pulse_state;
        res.dir_level   = state_next.dir_state;
        res.busy_res    = state_next.running;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.tx_index      <= INDEX_ONE;
            state_reg.rx_index      <= INDEX_ONE;
            state_reg.rx_high       <= '0;
            state_reg.step_target   <= '0;
            state_reg.run_direction <= 1'b0;
            state_reg.step_count    <= '0;
            state_reg.running       <= 1'b0;
            state_reg.pulse_state   <= 1'b1;
            state_reg.dir_state     <= 1'b1;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign result = res;

endmodule

`default_nettype wire

@@ rtl/smbus_slave_step_pulse_generator.sv @@
// Top level: input register, decode core and result register of the step pulse generator.
// An accepted item waits in the input register until advance registers its result.
// Throughput: one item per cycle while m_ready is high; the input register refills while
// the result register drains, so both sides may run at full rate.
// Reset (aresetn, synchronous, active low) clears both valid flags, the configuration
// registers and the bus and step state; payload registers are not reset.
`default_nettype none

module smbus_slave_step_pulse_generator
    import ssspg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [ByteWidth-1:0] cfg_data,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic                 s_command,
    input  wire logic [3:0]           s_bus_status,
    input  wire logic [ByteWidth-1:0] s_rx_byte,
    input  wire logic                 s_arb_lost,
    input  wire logic                 s_master_ack,
    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      logic                 m_ack_out,
    output      logic                 m_tx_load,
    output      logic [ByteWidth-1:0] m_tx_byte,
    output      logic                 m_bus_reset,
    output      logic                 m_command_loaded,
    output      logic                 m_pulse_level,
    output      logic                 m_dir_level,
    output      logic                 m_busy_res
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ssspg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssspg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.command    <= s_command;
            item_reg.bus_status <= s_bus_status;
            item_reg.rx_byte    <= s_rx_byte;
            item_reg.arb_lost   <= s_arb_lost;
            item_reg.master_ack <= s_master_ack;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_ack_out        = out_reg.ack_out;
    assign m_tx_load        = out_reg.tx_load;
    assign m_tx_byte        = out_reg.tx_byte;
    assign m_bus_reset      = out_reg.bus_reset;
    assign m_command_loaded = out_reg.command_loaded;
    assign m_pulse_level    = out_reg.pulse_level;
    assign m_dir_level      = out_reg.dir_level;
    assign m_busy_res       = out_reg.busy_res;

endmodule

`default_nettype wire

@@ rtl/ssspg_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module ssspg_checker
    import ssspg_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic                 m_ack_out,
    input wire logic                 m_tx_load,
    input wire logic [ByteWidth-1:0] m_tx_byte,
    input wire logic                 m_bus_reset,
    input wire logic                 m_command_loaded,
    input wire logic                 m_busy_res
);

    property p_held;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_busy_res);
    endproperty
    a_held: assert property (p_held) else $error("Stalled result item changed.");

    property p_no_tx;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_load |-> m_tx_byte == '0;
    endproperty
    a_no_tx: assert property (p_no_tx) else $error("Transmit byte set without a load.");

    property p_bus_reset;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_bus_reset |-> !m_ack_out && !m_tx_load && !m_command_loaded;
    endproperty
    a_bus_reset: assert property (p_bus_reset) else $error("Bus reset item carries activity.");

    property p_loaded;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_command_loaded |-> m_ack_out && m_busy_res && !m_tx_load;
    endproperty
    a_loaded: assert property (p_loaded) else $error("Loaded command without ack or run.");

endmodule

bind smbus_slave_step_pulse_generator ssspg_checker u_ssspg_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_ack_out        (m_ack_out),
    .m_tx_load        (m_tx_load),
    .m_tx_byte        (m_tx_byte),
    .m_bus_reset      (m_bus_reset),
    .m_command_loaded (m_command_loaded),
    .m_busy_res       (m_busy_res)
);

`default_nettype wire
